// ----- hdl/rme_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rme_pkg
// shared constants, types and helper functions for the euler angle block
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STAGES   = 16;
    localparam int CW            = 36;
    localparam int ZW            = 28;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cvec;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [15:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [15:0] e00;
        logic signed [15:0] e10;
        logic signed [15:0] e20;
        logic signed [15:0] e21;
        logic signed [15:0] e22;
        logic signed [15:0] e11;
        logic signed [15:0] e12;
    } t_mat;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = 28'sd13176795;
                1: v = 28'sd7778716;
                2: v = 28'sd4110060;
                3: v = 28'sd2086331;
                4: v = 28'sd1047214;
                5: v = 28'sd524117;
                6: v = 28'sd262123;
                7: v = 28'sd131069;
                default: v = (i < 24) ? (28'sd1 <<< (24 - i)) : 28'sd0;
            endcase
            return v;
        end
    endfunction

    // prerotation into the right half plane, inputs in q1.14
    function automatic t_cvec cordic_init(input logic signed [16:0] y,
                                          input logic signed [16:0] x);
        t_cvec v;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        begin
            xs = CW'(x) <<< 16;
            ys = CW'(y) <<< 16;
            v.zero = (x == 17'sd0) && (y == 17'sd0);
            v.z = '0;
            v.x = xs;
            v.y = ys;
            if (x < 0) begin
                if (y >= 0) begin
                    v.x = ys;
                    v.y = -xs;
                    v.z = HALF_PI_Q24;
                end else begin
                    v.x = -ys;
                    v.y = xs;
                    v.z = -HALF_PI_Q24;
                end
            end
            return v;
        end
    endfunction

    function automatic logic signed [15:0] cordic_final(input t_cvec v);
        logic signed [ZW-1:0] r;
        begin
            r = (v.z + ZW'(1024)) >>> 11;
            if (v.zero) begin
                r = '0;
            end else if (r > ZW'(PI_Q13)) begin
                r = ZW'(PI_Q13);
            end else if (r < -ZW'(PI_Q13)) begin
                r = -ZW'(PI_Q13);
            end
            return r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rme_cordic_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rme_cordic_cell
// one vectoring cordic stage with three lanes, registered
// ----------------------------------------------------------------------------
module rme_cordic_cell
    import rme_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [4:0] i_stage,
    input  wire t_cvec      i_a,
    input  wire t_cvec      i_b,
    input  wire t_cvec      i_c,
    output t_cvec           o_a,
    output t_cvec           o_b,
    output t_cvec           o_c
);

    t_cvec r_a, r_b, r_c;

    function automatic t_cvec step(input t_cvec v, input logic [4:0] s);
        t_cvec w;
        begin
            w = v;
            if (v.y >= 0) begin
                w.x = v.x + (v.y >>> s);
                w.y = v.y - (v.x >>> s);
                w.z = v.z + atan_q24(int'(s));
            end else begin
                w.x = v.x - (v.y >>> s);
                w.y = v.y + (v.x >>> s);
                w.z = v.z - atan_q24(int'(s));
            end
            return w;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= step(i_a, i_stage);
            r_b <= step(i_b, i_stage);
            r_c <= step(i_c, i_stage);
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;

endmodule
`default_nettype wire

// ----- hdl/rme_sqrt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// one restoring square root digit, carries the matrix alongside
// ----------------------------------------------------------------------------
module rme_sqrt_cell
    import rme_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_sqrt i_s,
    input  wire t_mat  i_m,
    output t_sqrt      o_s,
    output t_mat       o_m
);

    t_sqrt r_s;
    t_mat  r_m;
    t_sqrt n_s;
    logic [33:0] rem2;
    logic [33:0] trial;

    always_comb begin
        rem2  = {i_s.rem, i_s.num[31:30]};
        trial = {16'd0, i_s.root, 2'b01};
        n_s.num = {i_s.num[29:0], 2'b00};
        if (rem2 >= trial) begin
            n_s.rem  = 32'(rem2 - trial);
            n_s.root = {i_s.root[14:0], 1'b1};
        end else begin
            n_s.rem  = rem2[31:0];
            n_s.root = {i_s.root[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
            r_m <= i_m;
        end
    end

    assign o_s = r_s;
    assign o_m = r_m;

endmodule
`default_nettype wire

// ----- hdl/rotation_matrix_to_euler_zyx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx
// stages: 1 square stage + 16 root cells + 1 select stage + 16 cordic cells
//   + 1 output stage, each registered, from input beat to output beat
// throughput: one matrix per cycle; the whole chain halts while o_valid
//   waits on i_ready
// synchronous active-low reset clears valid bits, threshold resets to 1
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx
    import rme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [14:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic signed [15:0] i_elem_00,
    input  wire logic signed [15:0] i_elem_10,
    input  wire logic signed [15:0] i_elem_20,
    input  wire logic signed [15:0] i_elem_21,
    input  wire logic signed [15:0] i_elem_22,
    input  wire logic signed [15:0] i_elem_11,
    input  wire logic signed [15:0] i_elem_12,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic             o_singular_flag
);

    localparam int DEPTH = SQRT_STAGES + CORDIC_STAGES + 3;

    logic [14:0]      r_thresh;
    logic [DEPTH-1:0] r_vld;
    logic             adv;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 15'd1;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (adv) begin
                r_vld <= {r_vld[DEPTH-2:0], i_valid};
            end
        end
    end

    // squares
    t_mat  r_m0;
    t_sqrt r_s0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0 <= {i_elem_00, i_elem_10, i_elem_20, i_elem_21,
                     i_elem_22, i_elem_11, i_elem_12};
            r_s0.num  <= 32'(32'(i_elem_00) * 32'(i_elem_00))
                       + 32'(32'(i_elem_10) * 32'(i_elem_10));
            r_s0.rem  <= '0;
            r_s0.root <= '0;
        end
    end

    t_sqrt s_chain [SQRT_STAGES+1];
    t_mat  m_chain [SQRT_STAGES+1];
    assign s_chain[0] = r_s0;
    assign m_chain[0] = r_m0;

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        rme_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_s   (s_chain[g]),
            .i_m   (m_chain[g]),
            .o_s   (s_chain[g+1]),
            .o_m   (m_chain[g+1])
        );
    end

    // branch select and prerotation
    t_mat  sm;
    logic  [15:0] sy;
    logic  sing;
    t_cvec r_ia, r_ib, r_ic;
    logic  r_sing;
    assign sm   = m_chain[SQRT_STAGES];
    assign sy   = s_chain[SQRT_STAGES].root;
    assign sing = sy < {1'b0, r_thresh};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sing <= sing;
            r_ib   <= cordic_init(-17'(sm.e20), {1'b0, sy});
            if (sing) begin
                r_ia <= cordic_init(-17'(sm.e12), 17'(sm.e11));
            end else begin
                r_ia <= cordic_init(17'(sm.e21), 17'(sm.e22));
            end
            r_ic <= cordic_init(17'(sm.e10), 17'(sm.e00));
        end
    end

    t_cvec ca [CORDIC_STAGES+1];
    t_cvec cb [CORDIC_STAGES+1];
    t_cvec cc [CORDIC_STAGES+1];
    logic  [CORDIC_STAGES-1:0] r_sflag;
    assign ca[0] = r_ia;
    assign cb[0] = r_ib;
    assign cc[0] = r_ic;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sflag <= {r_sflag[CORDIC_STAGES-2:0], r_sing};
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        rme_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_stage (5'(g)),
            .i_a     (ca[g]),
            .i_b     (cb[g]),
            .i_c     (cc[g]),
            .o_a     (ca[g+1]),
            .o_b     (cb[g+1]),
            .o_c     (cc[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_roll_angle    <= cordic_final(ca[CORDIC_STAGES]);
            o_pitch_angle   <= cordic_final(cb[CORDIC_STAGES]);
            o_yaw_angle     <= r_sflag[CORDIC_STAGES-1] ? 16'sd0
                                                        : cordic_final(cc[CORDIC_STAGES]);
            o_singular_flag <= r_sflag[CORDIC_STAGES-1];
        end
    end

endmodule
`default_nettype wire

// ----- bench/tb_rotation_matrix_to_euler_zyx.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_zyx
// drives rotation matrices through the euler angle block with random idling
// and a long output stall, predicts roll, pitch, yaw and the gimbal-lock flag
// with a cordic model, and compares every output beat in order
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_zyx;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY        = 35;
    localparam int HOLD_CYCLES    = 200;

    typedef struct {
        logic signed [15:0] e00, e10, e20, e21, e22, e11, e12;
    } t_elem_set;

    typedef struct {
        logic signed [15:0] roll, pitch, yaw;
        logic               singular;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [14:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [15:0] i_elem_00 = '0, i_elem_10 = '0, i_elem_20 = '0, i_elem_21 = '0;
    logic signed [15:0] i_elem_22 = '0, i_elem_11 = '0, i_elem_12 = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_roll_angle, o_pitch_angle, o_yaw_angle;
    logic o_singular_flag;

    rotation_matrix_to_euler_zyx dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_elem_set pending_matrices[$];
    t_angles expected_angles[$];
    logic [14:0] threshold = 15'd1;
    int error_count = 0;
    int idle_pct = 37;
    logic long_stall = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;
    logic o_ready_seen = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] cordic_atan2(longint y, longint x);
        longint z, t, xs, ys;
        longint atan_tab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                 262123, 131069, 65536, 32768, 16384, 8192, 4096,
                                 2048, 1024, 512};
        if (x == 0 && y == 0) return 16'sd0;
        z = 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 26353589;
            end else begin
                t = x; x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
        end
        z = floor_shift(z + 1024, 11);
        if (z > 25736) z = 25736;
        if (z < -25736) z = -25736;
        return z[15:0];
    endfunction

    function automatic t_angles euler_of(t_elem_set m);
        t_angles a;
        longint sum, sy;
        sum = longint'(m.e00) * m.e00 + longint'(m.e10) * m.e10;
        sy = 0;
        while ((sy + 1) * (sy + 1) <= sum) sy++;
        a.singular = (sy < longint'(threshold));
        a.pitch = cordic_atan2(-longint'(m.e20), sy);
        if (!a.singular) begin
            a.roll = cordic_atan2(m.e21, m.e22);
            a.yaw = cordic_atan2(m.e10, m.e00);
        end else begin
            a.roll = cordic_atan2(-longint'(m.e12), m.e11);
            a.yaw = 16'sd0;
        end
        return a;
    endfunction

    function automatic logic signed [15:0] rand_elem();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom());
        if (k == 1) return 16'(int'($urandom_range(0, 32)) - 16);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_elem_set rand_matrix();
        t_elem_set m;
        m.e00 = rand_elem(); m.e10 = rand_elem(); m.e20 = rand_elem();
        m.e21 = rand_elem(); m.e22 = rand_elem(); m.e11 = rand_elem();
        m.e12 = rand_elem();
        if ($urandom_range(0, 5) == 0) begin
            m.e00 = 16'(int'($urandom_range(0, 8)) - 4);
            m.e10 = 16'(int'($urandom_range(0, 8)) - 4);
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_threshold(logic [14:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
    endtask

    task automatic queue_matrix(t_elem_set m);
        pending_matrices.insert(pending_matrices.size(), m);
    endtask

    task automatic wait_drained();
        while (pending_matrices.size() != 0 || i_valid || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || (i_valid && o_ready_seen)) begin
                if (pending_matrices.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    t_elem_set m;
                    m = pending_matrices.pop_front();
                    i_elem_00 <= m.e00; i_elem_10 <= m.e10; i_elem_20 <= m.e20;
                    i_elem_21 <= m.e21; i_elem_22 <= m.e22; i_elem_11 <= m.e11;
                    i_elem_12 <= m.e12;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (long_stall && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // input acceptance, sampled at the rising edge
    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            t_elem_set m;
            m.e00 = i_elem_00; m.e10 = i_elem_10; m.e20 = i_elem_20;
            m.e21 = i_elem_21; m.e22 = i_elem_22; m.e11 = i_elem_11;
            m.e12 = i_elem_12;
            expected_angles.insert(expected_angles.size(), euler_of(m));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                t_angles e;
                e = expected_angles.pop_front();
                if (o_roll_angle !== e.roll)
                    report_mismatch("roll", int'(o_roll_angle), int'(e.roll));
                if (o_pitch_angle !== e.pitch)
                    report_mismatch("pitch", int'(o_pitch_angle), int'(e.pitch));
                if (o_yaw_angle !== e.yaw)
                    report_mismatch("yaw", int'(o_yaw_angle), int'(e.yaw));
                if (o_singular_flag !== e.singular)
                    report_mismatch("singular", int'(o_singular_flag), int'(e.singular));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_elem_set m;
        logic [14:0] settings[4] = '{15'd0, 15'd16384, 15'd32767, 15'd8000};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero vectors, negative x on the axis
        queue_matrix('{16'sd16384, 0, 0, 0, 16'sd16384, 16'sd16384, 0});
        queue_matrix('{0, 0, 0, 0, 0, 0, 0});
        queue_matrix('{-16'sd16384, 0, 16'sd16384, 0, -16'sd16384, -16'sd16384, 0});
        queue_matrix('{0, 16'sd16384, -16'sd16384, 16'sd16384, 0, 0, 16'sd16384});
        queue_matrix('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh8000, 16'sh8000});
        queue_matrix('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                       16'sd32767, 16'sd32767, 16'sd32767});
        queue_matrix('{0, 0, -16'sd16384, 0, 0, 16'sd16384, -16'sd16384});
        queue_matrix('{1, 0, 0, -16'sd5, -16'sd7, -16'sd3, 16'sd9});
        queue_matrix('{0, 1, 16'sd100, 0, -16'sd1, 0, 0});
        wait_drained();

        foreach (settings[s]) begin
            write_threshold(settings[s]);
            if (s == 1) begin
                idle_pct = 0;
                long_stall = 1'b1;
            end else begin
                idle_pct = 37;
            end
            repeat (150) begin
                m = rand_matrix();
                queue_matrix(m);
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
